// ----- src/utf16f_pkg.sv -----
package utf16f_pkg;

	// queue between the classifier and the byte sequencer
	localparam int QUEUE_DEPTH = 4;

	localparam logic [15:0] HIGH_FIRST = 16'hD800;
	localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
	localparam logic [15:0] LOW_FIRST  = 16'hDC00;
	localparam logic [15:0] LOW_LAST   = 16'hDFFF;
	localparam logic [10:0] PAIR_BIAS  = 11'h040;   // 0x10000 >> 10
	localparam logic [20:0] REPL_CP    = 21'h00FFFD;

	localparam logic [7:0] REPL_B0 = 8'hEF;
	localparam logic [7:0] REPL_B1 = 8'hBF;
	localparam logic [7:0] REPL_B2 = 8'hBD;
	localparam logic [2:0] REPL_LEN = 3'd3;

	// one queue entry: optional replacement char, then an optional code point
	typedef struct packed {
		logic        pre;
		logic        cp_en;
		logic [20:0] cp;
	} cmd_t;

	function automatic logic is_dropped(input logic [20:0] cp);
		is_dropped = (cp >= 21'h1F300 && cp <= 21'h1F6FF) ||
		             (cp >= 21'h1F900 && cp <= 21'h1FA6F) ||
		             (cp >= 21'h02600 && cp <= 21'h027BF);
	endfunction

	function automatic logic [2:0] utf8_len(input logic [20:0] cp);
		if (cp < 21'h80)
			utf8_len = 3'd1;
		else if (cp < 21'h800)
			utf8_len = 3'd2;
		else if (cp < 21'h10000)
			utf8_len = 3'd3;
		else
			utf8_len = 3'd4;
	endfunction

	// byte at position pos of the utf-8 form of cp, len bytes long
	function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
	                                         input logic [2:0] pos);
		logic [7:0] b;
		b = 8'h00;
		case (len)
			3'd1: b = {1'b0, cp[6:0]};
			3'd2: begin
				case (pos)
					3'd0:    b = {3'b110, cp[10:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			3'd3: begin
				case (pos)
					3'd0:    b = {4'b1110, cp[15:12]};
					3'd1:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			default: begin
				case (pos)
					3'd0:    b = {5'b11110, cp[20:18]};
					3'd1:    b = {2'b10, cp[17:12]};
					3'd2:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
		endcase
		utf8_byte = b;
	endfunction

endpackage

// ----- src/utf16f_front.sv -----
module utf16f_front
	import utf16f_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // code_unit
	input  logic        s_axis_tlast,   // last_unit
	input  logic        full,
	output logic        push,
	output cmd_t        push_cmd
);

	logic       held_q;
	logic [9:0] held_bits_q;
	logic       held_d;
	logic [9:0] held_bits_d;
	logic       accept;
	logic       is_high;
	logic       is_low;
	logic [20:0] pair_cp;
	logic [20:0] unit_cp;

	assign s_axis_tready = !full;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign is_high = s_axis_tdata >= HIGH_FIRST && s_axis_tdata <= HIGH_LAST;
	assign is_low = s_axis_tdata >= LOW_FIRST && s_axis_tdata <= LOW_LAST;
	assign pair_cp = {11'({1'b0, held_bits_q}) + PAIR_BIAS, s_axis_tdata[9:0]};
	assign unit_cp = {5'd0, s_axis_tdata};

	always_comb begin
		push_cmd = '0;
		held_d = held_q;
		held_bits_d = held_bits_q;
		if (held_q && is_low) begin
			push_cmd.cp = pair_cp;
			push_cmd.cp_en = !is_dropped(pair_cp);
			held_d = 1'b0;
			held_bits_d = '0;
		end else begin
			// a held high unit not followed by a low one becomes a replacement
			push_cmd.pre = held_q;
			held_d = 1'b0;
			held_bits_d = '0;
			if (is_high) begin
				if (s_axis_tlast) begin
					push_cmd.cp = REPL_CP;
					push_cmd.cp_en = 1'b1;
				end else begin
					held_d = 1'b1;
					held_bits_d = s_axis_tdata[9:0];
				end
			end else if (is_low) begin
				push_cmd.cp = REPL_CP;
				push_cmd.cp_en = 1'b1;
			end else begin
				push_cmd.cp = unit_cp;
				push_cmd.cp_en = !is_dropped(unit_cp);
			end
		end
	end

	assign push = accept && (push_cmd.pre || push_cmd.cp_en);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
			held_bits_q <= '0;
		end else if (accept) begin
			held_q <= held_d;
			held_bits_q <= held_bits_d;
		end
	end

	a_end_clears_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_axis_tlast |=> !held_q)
		else $error("high unit still held after end of text");

	a_push_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_cmd.pre || push_cmd.cp_en))
		else $error("queued entry carries no bytes");

	a_hold_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !held_q && is_high && !s_axis_tlast |-> !push)
		else $error("held high unit produced an entry");

endmodule

// ----- src/utf16f_fifo.sv -----
module utf16f_fifo
	import utf16f_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic empty
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	cmd_t            mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full = count_q == CntW'(DEPTH);
	assign empty = count_q == '0;
	assign pop_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			if (push && !pop)
				count_q <= count_q + CntW'(1);
			else if (pop && !push)
				count_q <= count_q - CntW'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(DEPTH))
		else $error("queue count past depth");

endmodule

// ----- src/utf16f_back.sv -----
module utf16f_back
	import utf16f_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       empty,
	input  cmd_t       pop_cmd,
	output logic       pop,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // out_byte
	output logic       m_axis_tlast    // run_end
);

	logic        busy_q;
	logic        pre_q;
	logic        cp_en_q;
	logic [20:0] cp_q;
	logic [2:0]  len_q;
	logic [2:0]  idx_q;
	logic [2:0]  total_q;
	logic        valid_q;
	logic [7:0]  byte_q;
	logic        last_q;

	logic        out_free;
	logic        send;
	logic        is_last;
	logic [2:0]  new_len;
	logic [2:0]  new_total;
	logic [2:0]  pos;
	logic [7:0]  cur_byte;

	assign out_free = !valid_q || m_axis_tready;
	assign send = busy_q && out_free;
	assign is_last = idx_q == total_q - 3'd1;
	assign pop = !empty && (!busy_q || (send && is_last));

	assign new_len = utf8_len(pop_cmd.cp);
	assign new_total = (pop_cmd.pre ? REPL_LEN : 3'd0) + (pop_cmd.cp_en ? new_len : 3'd0);

	always_comb begin
		pos = pre_q ? idx_q - REPL_LEN : idx_q;
		if (pre_q && idx_q < REPL_LEN) begin
			case (idx_q)
				3'd0:    cur_byte = REPL_B0;
				3'd1:    cur_byte = REPL_B1;
				default: cur_byte = REPL_B2;
			endcase
		end else begin
			cur_byte = utf8_byte(cp_q, len_q, pos);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pre_q <= pop_cmd.pre;
			cp_en_q <= pop_cmd.cp_en;
			cp_q <= pop_cmd.cp;
			len_q <= new_len;
			total_q <= new_total;
		end
		if (send) begin
			byte_q <= cur_byte;
			last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q <= '0;
			end else if (send) begin
				idx_q <= idx_q + 3'd1;
				if (is_last)
					busy_q <= 1'b0;
			end
			if (send)
				valid_q <= 1'b1;
			else if (m_axis_tready)
				valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata = byte_q;
	assign m_axis_tlast = last_q;

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q < total_q)
		else $error("byte index past end of entry");

	a_entry_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (pre_q || cp_en_q))
		else $error("working entry carries no bytes");

	a_pop_only_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		pop && busy_q |-> send && is_last)
		else $error("entry replaced before its last byte left");

endmodule

// ----- src/utf16_emoji_filter_to_utf8_core.sv -----
// utf-16 to utf-8 transcoder with emoji filter. code units enter on the s_axis side, one
// item per accepted beat, tlast marking the final unit of a text; utf-8 bytes leave on the
// m_axis side, one byte per item, tlast set on the last byte caused by an input unit. a high
// surrogate is held until the next unit; a valid pair becomes one supplementary code point;
// any surrogate that does not pair (including a high one held at end of text) becomes
// U+FFFD (ef bf bd). code points in U+1F300..U+1F6FF, U+1F900..U+1FA6F and U+2600..U+27BF
// are dropped, so a unit may cause no bytes at all and then no tlast is seen for it.
// rate: the classifier takes one unit per cycle while the queue has room; the byte
// sequencer sends one byte per cycle while the output is free, and a unit makes 0 to 6
// bytes, typically 1 to 3. the first byte of a unit passes through the queue, the
// sequencer's entry registers and the output byte register before it is offered.
module utf16_emoji_filter_to_utf8_core
	import utf16f_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH   // entries in the classifier-to-sequencer queue, >= 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
	input  logic        s_axis_tlast,   // last_unit
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
	output logic        m_axis_tlast    // run_end
);

	// queue handshake between the two halves
	logic push;
	logic pop;
	logic full;
	logic empty;
	cmd_t push_cmd;
	cmd_t pop_cmd;

	// front: surrogate pairing, replacement and emoji filtering
	utf16f_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.full          (full),
		.push          (push),
		.push_cmd      (push_cmd)
	);

	// short queue of code point entries so either side can stall alone
	utf16f_fifo #(
		.DEPTH (DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (empty)
	);

	// back: utf-8 byte sequencer with registered output
	utf16f_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.empty         (empty),
		.pop_cmd       (pop_cmd),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ----- tb/sv/utf16_emoji_filter_to_utf8_core_tb.sv -----
module utf16_emoji_filter_to_utf8_core_tb
	import utf16f_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// generous ceiling: worst case is ~2.5k bytes each waiting out a long stall
	localparam int CYCLE_LIMIT = 400000;

	// boundaries of the dropped ranges
	localparam logic [20:0] SYM_FIRST   = 21'h02600;
	localparam logic [20:0] SYM_LAST    = 21'h027BF;
	localparam logic [20:0] PICT_FIRST  = 21'h1F300;
	localparam logic [20:0] PICT_LAST   = 21'h1F6FF;
	localparam logic [20:0] SUPPL_FIRST = 21'h1F900;
	localparam logic [20:0] SUPPL_LAST  = 21'h1FA6F;
	localparam logic [20:0] SUPP_BASE   = 21'h10000;

	// one utf-8 byte as it should leave the block
	typedef struct packed {
		logic [7:0] data;
		logic       run_end;
	} utf8_item_t;

	// keeps its own copy of the held high surrogate and the bytes still owed
	class transcode_scoreboard;
		bit         held_valid;
		logic [9:0] held_bits;
		utf8_item_t due_bytes[$];
		int         errors;

		function new();
			held_valid = 1'b0;
			held_bits  = '0;
			errors     = 0;
		endfunction

		function bit emoji_cp(logic [20:0] cp);
			return (cp >= PICT_FIRST && cp <= PICT_LAST) ||
			       (cp >= SUPPL_FIRST && cp <= SUPPL_LAST) ||
			       (cp >= SYM_FIRST && cp <= SYM_LAST);
		endfunction

		function void push_byte(logic [7:0] b);
			utf8_item_t it;
			it.data    = b;
			it.run_end = 1'b0;
			due_bytes.insert(due_bytes.size(), it);
		endfunction

		// utf-8 form of one code point, unless it is in a dropped range
		function void encode_cp(logic [20:0] cp);
			if (emoji_cp(cp))
				return;
			if (cp < 21'h80) begin
				push_byte({1'b0, cp[6:0]});
			end else if (cp < 21'h800) begin
				push_byte({3'b110, cp[10:6]});
				push_byte({2'b10, cp[5:0]});
			end else if (cp < SUPP_BASE) begin
				push_byte({4'b1110, cp[15:12]});
				push_byte({2'b10, cp[11:6]});
				push_byte({2'b10, cp[5:0]});
			end else begin
				push_byte({5'b11110, cp[20:18]});
				push_byte({2'b10, cp[17:12]});
				push_byte({2'b10, cp[11:6]});
				push_byte({2'b10, cp[5:0]});
			end
		endfunction

		// an accepted code unit: work out the bytes it causes
		function void note_unit(logic [15:0] cu, logic last);
			int prior_count;
			bit high;
			bit low;
			prior_count = due_bytes.size();
			high   = (cu >= HIGH_FIRST && cu <= HIGH_LAST);
			low    = (cu >= LOW_FIRST && cu <= LOW_LAST);
			if (held_valid && low) begin
				encode_cp(SUPP_BASE + {1'b0, held_bits, cu[9:0]});
				held_valid = 1'b0;
				held_bits  = '0;
			end else begin
				if (held_valid) begin
					encode_cp(REPL_CP);
					held_valid = 1'b0;
					held_bits  = '0;
				end
				if (high && !last) begin
					held_valid = 1'b1;
					held_bits  = cu[9:0];
				end else if (high || low) begin
					encode_cp(REPL_CP);
				end else begin
					encode_cp({5'b0, cu});
				end
			end
			if (due_bytes.size() > prior_count)
				due_bytes[due_bytes.size() - 1].run_end = 1'b1;
		endfunction

		function void flag(string what, logic [8:0] want, logic [8:0] got);
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
		endfunction

		// an accepted byte: compare with the oldest one owed
		function void check_byte(logic [7:0] b, logic run_end);
			utf8_item_t want;
			if (due_bytes.size() == 0) begin
				errors++;
				$display("%0t: unexpected byte, expected none, actual %h tlast %b",
				         $time, b, run_end);
				return;
			end
			want = due_bytes.pop_front();
			if (want.data !== b)
				flag("byte", {1'b0, want.data}, {1'b0, b});
			if (want.run_end !== run_end)
				flag("tlast", {8'b0, want.run_end}, {8'b0, run_end});
		endfunction
	endclass

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata  = '0;   // [15:0] code_unit
	logic        s_axis_tlast  = 1'b0; // last_unit
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;         // [7:0] out_byte
	logic        m_axis_tlast;         // run_end

	transcode_scoreboard sb = new();

	// when set the sender offers items back to back
	bit tx_calm = 1'b0;

	utf16_emoji_filter_to_utf8_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog on the whole run
	initial begin
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("utf16_emoji_filter_to_utf8_core_tb failed");
				$finish;
			end
		end
	end

	// sender gap: mostly none or short, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (tx_calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic rand_last();
		return ($urandom_range(0, 15) == 0);
	endfunction

	// offer one code unit, wait for the handshake, then maybe idle a while
	// must be entered just after a rising edge
	task automatic send_unit(input logic [15:0] cu, input logic last);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= cu;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_unit(cu, last);
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// sender pauses until every owed byte has come out
	task automatic drain_wait();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (sb.due_bytes.size() != 0);
	endtask

	task automatic send_pair(input logic [15:0] hi, input logic [15:0] lo, input logic last);
		send_unit(hi, 1'b0);
		send_unit(lo, last);
	endtask

	// random text: mostly well-formed characters and pairs, some broken
	// surrogates and plain noise
	task automatic random_text(input int count);
		int done;
		int next_mode;
		int r;
		logic [15:0] hi;
		logic [15:0] lo;
		logic [15:0] cu;
		done      = 0;
		next_mode = 0;
		while (done < count) begin
			if (done >= next_mode) begin
				tx_calm   = ($urandom_range(0, 3) == 0);
				next_mode = done + 40;
			end
			r  = $urandom_range(0, 99);
			hi = $urandom_range(0, 1) ? 16'($urandom_range(16'hD800, 16'hDBFF))
			                         : 16'($urandom_range(16'hD83C, 16'hD83E));
			lo = 16'($urandom_range(16'hDC00, 16'hDFFF));
			if (r < 25) begin
				// ascii
				send_unit(16'($urandom_range(0, 16'h007F)), rand_last());
				done++;
			end else if (r < 38) begin
				// two-byte range
				send_unit(16'($urandom_range(16'h0080, 16'h07FF)), rand_last());
				done++;
			end else if (r < 53) begin
				// three-byte range, clear of the surrogates
				cu = $urandom_range(0, 1) ? 16'($urandom_range(16'h0800, 16'hD7FF))
				                         : 16'($urandom_range(16'hE000, 16'hFFFF));
				send_unit(cu, rand_last());
				done++;
			end else if (r < 60) begin
				// around the dropped symbol block
				send_unit(16'($urandom_range(16'h25F0, 16'h27CF)), rand_last());
				done++;
			end else if (r < 80) begin
				// well-formed pair, often in the emoji planes
				send_pair(hi, lo, rand_last());
				done += 2;
			end else if (r < 85) begin
				// lone low surrogate
				send_unit(lo, rand_last());
				done++;
			end else if (r < 90) begin
				// held high followed by something that is not a low surrogate
				cu = 16'($urandom);
				if (cu >= LOW_FIRST && cu <= LOW_LAST)
					cu = cu ^ 16'h2000;
				send_pair(hi, cu, rand_last());
				done += 2;
			end else if (r < 94) begin
				// high surrogate ending the text
				send_unit(hi, 1'b1);
				done++;
			end else begin
				// raw noise
				send_unit(16'($urandom), rand_last());
				done++;
			end
		end
		tx_calm = 1'b0;
	endtask

	// receiver: checks every accepted byte, stalls at random, and once holds
	// off for a long stretch so that the queue fills and the input backs up
	initial begin
		int  hold_left;
		int  stall_left;
		int  bytes_seen;
		int  phase_left;
		bit  hold_done;
		bit  calm;
		int  r;
		hold_left  = 0;
		stall_left = 0;
		bytes_seen = 0;
		phase_left = 0;
		hold_done  = 1'b0;
		calm       = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				sb.check_byte(m_axis_tdata, m_axis_tlast);
				bytes_seen++;
			end
			// switch between calm and stalling phases now and then
			if (phase_left == 0) begin
				calm       = ($urandom_range(0, 3) == 0);
				phase_left = 128;
			end
			phase_left--;
			if (!hold_done && bytes_seen >= 250) begin
				hold_done = 1'b1;
				hold_left = 500;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (calm) begin
				m_axis_tready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					m_axis_tready <= 1'b1;
				end else begin
					// this cycle is a stall too, plus any extra
					stall_left = (r < 97) ? $urandom_range(0, 2) : $urandom_range(10, 30);
					m_axis_tready <= 1'b0;
				end
			end
		end
	end

	// stimulus
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes and utf-8 length boundaries
		send_unit(16'h0000, 1'b0);
		send_unit(16'h007F, 1'b1);
		send_unit(16'h0080, 1'b0);
		send_unit(16'h07FF, 1'b0);
		send_unit(16'h0800, 1'b0);
		send_unit(16'hFFFF, 1'b0);
		// symbol block edges, dropped even at end of text
		send_unit(16'h2600, 1'b1);
		send_unit(16'h27BF, 1'b0);
		// smallest and largest supplementary code points
		send_pair(16'hD800, 16'hDC00, 1'b0);
		send_pair(16'hDBFF, 16'hDFFF, 1'b1);
		// emoji plane edges: dropped, kept just outside
		send_pair(16'hD83C, 16'hDF00, 1'b0);
		send_pair(16'hD83D, 16'hDEFF, 1'b0);
		send_pair(16'hD83D, 16'hDF00, 1'b0);
		send_pair(16'hD83E, 16'hDD00, 1'b0);
		send_pair(16'hD83E, 16'hDE70, 1'b0);
		// lone low surrogate
		send_unit(16'hDFFF, 1'b0);
		// held high then an ordinary unit
		send_pair(16'hD801, 16'h0041, 1'b0);
		// held high then another high that does pair up
		send_unit(16'hD802, 1'b0);
		send_pair(16'hDBFF, 16'hDC00, 1'b0);
		// high surrogate ending the text, alone and after a held one
		send_unit(16'hDABC, 1'b1);
		send_pair(16'hD8FF, 16'hDAAA, 1'b1);

		drain_wait();
		random_text(190);
		drain_wait();
		random_text(190);
		drain_wait();

		// keep the clock running to catch stray bytes
		repeat (16) @(posedge clk);
		if (sb.errors == 0)
			$display("utf16_emoji_filter_to_utf8_core_tb passed");
		else
			$display("utf16_emoji_filter_to_utf8_core_tb failed");
		$finish;
	end

endmodule
